// ----- rtl/core/json_string_unescape_to_utf8_assert.svh -----
// Assertion macros shared by the JSON string unescaper RTL.
`ifndef JSON_STRING_UNESCAPE_TO_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_TO_UTF8_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define JSU_ASSERT_NOW(name, pre, con, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (con)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define JSU_ASSERT_NEXT(name, pre, con, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (con)) else $error(msg);

`endif

// ----- rtl/core/jsu_pkg.sv -----
// Shared types, codes and helper functions of the JSON string unescaper.
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BODY,
    PH_ESC,
    PH_HEX1,
    PH_WANT_BS,
    PH_WANT_U,
    PH_HEX2
  } phase_t;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // One run: all results caused by one input byte, first result in bytes[0].
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic [1:0]      kind;
  } run_t;

  // Returns {bad, value}; bad is set when the byte is not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
        hex_val = {1'b0, d[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = c - 8'h57;
        hex_val = {1'b0, d[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = c - 8'h37;
        hex_val = {1'b0, d[3:0]};
      end else begin
        hex_val = 5'h10;
      end
    end
  endfunction

endpackage

// ----- rtl/core/jsu_front.sv -----
// Front end: parses one input byte per cycle while take is high and forms the run of results it causes.
module jsu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    in_byte,
  output logic          push,
  output jsu_pkg::run_t push_run,
  output logic          idle
);

  jsu_pkg::phase_t phase, phase_next;
  logic [1:0]  hcnt, hcnt_next;
  logic [15:0] fcu, fcu_next;
  logic [15:0] acc, acc_next;

  logic [4:0]  hv;
  logic [15:0] acc_sh;
  logic [10:0] hi;
  logic [20:0] cp21;
  logic        fail;
  logic        done;

  assign hv     = jsu_pkg::hex_val(in_byte);
  assign acc_sh = {acc[11:0], hv[3:0]};
  // Surrogate pair: upper bits of the code point are the high unit plus 0x40.
  assign hi     = {1'b0, fcu[9:0]} + 11'h040;
  assign cp21   = {hi, acc_sh[9:0]};
  assign idle   = (phase == jsu_pkg::PH_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jsu_pkg::PH_IDLE;
      hcnt  <= 2'd0;
      fcu   <= 16'h0000;
      acc   <= 16'h0000;
    end else begin
      phase <= phase_next;
      hcnt  <= hcnt_next;
      fcu   <= fcu_next;
      acc   <= acc_next;
    end
  end

  always_comb begin
    phase_next = phase;
    hcnt_next  = hcnt;
    fcu_next   = fcu;
    acc_next   = acc;
    push_run   = '0;
    fail       = 1'b0;
    done       = 1'b0;
    if (take) begin
      unique case (phase)
        jsu_pkg::PH_IDLE: begin
          if (in_byte == jsu_pkg::CH_QUOTE) phase_next = jsu_pkg::PH_BODY;
          else fail = 1'b1;
        end
        jsu_pkg::PH_BODY: begin
          if (in_byte < jsu_pkg::CH_SPACE) begin
            fail = 1'b1;
          end else if (in_byte == jsu_pkg::CH_BSLASH) begin
            phase_next = jsu_pkg::PH_ESC;
          end else if (in_byte == jsu_pkg::CH_QUOTE) begin
            done = 1'b1;
          end else begin
            push_run.bytes[0] = in_byte;
            push_run.cnt      = 3'd1;
          end
        end
        jsu_pkg::PH_ESC: begin
          phase_next   = jsu_pkg::PH_BODY;
          push_run.cnt = 3'd1;
          unique case (in_byte) inside
            jsu_pkg::CH_B: push_run.bytes[0] = 8'h08;
            jsu_pkg::CH_T: push_run.bytes[0] = 8'h09;
            jsu_pkg::CH_N: push_run.bytes[0] = 8'h0A;
            jsu_pkg::CH_F: push_run.bytes[0] = 8'h0C;
            jsu_pkg::CH_R: push_run.bytes[0] = 8'h0D;
            jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH, jsu_pkg::CH_QUOTE:
              push_run.bytes[0] = in_byte;
            jsu_pkg::CH_U: begin
              push_run.cnt = 3'd0;
              phase_next   = jsu_pkg::PH_HEX1;
              hcnt_next    = 2'd0;
              acc_next     = 16'h0000;
            end
            default: begin
              push_run.cnt = 3'd0;
              fail         = 1'b1;
            end
          endcase
        end
        jsu_pkg::PH_HEX1: begin
          if (hv[4]) begin
            fail = 1'b1;
          end else begin
            acc_next = acc_sh;
            if (hcnt == 2'd3) begin
              hcnt_next  = 2'd0;
              phase_next = jsu_pkg::PH_BODY;
              if (acc_sh <= 16'h007F) begin
                push_run.bytes[0] = acc_sh[7:0];
                push_run.cnt      = 3'd1;
              end else if (acc_sh <= 16'h07FF) begin
                push_run.bytes[0] = {3'b110, acc_sh[10:6]};
                push_run.bytes[1] = {2'b10, acc_sh[5:0]};
                push_run.cnt      = 3'd2;
              end else if (acc_sh >= 16'hD800 && acc_sh <= 16'hDBFF) begin
                fcu_next   = acc_sh;
                phase_next = jsu_pkg::PH_WANT_BS;
              end else begin
                push_run.bytes[0] = {4'b1110, acc_sh[15:12]};
                push_run.bytes[1] = {2'b10, acc_sh[11:6]};
                push_run.bytes[2] = {2'b10, acc_sh[5:0]};
                push_run.cnt      = 3'd3;
              end
            end else begin
              hcnt_next = hcnt + 2'd1;
            end
          end
        end
        jsu_pkg::PH_WANT_BS: begin
          if (in_byte == jsu_pkg::CH_BSLASH) phase_next = jsu_pkg::PH_WANT_U;
          else fail = 1'b1;
        end
        jsu_pkg::PH_WANT_U: begin
          if (in_byte == jsu_pkg::CH_U) begin
            phase_next = jsu_pkg::PH_HEX2;
            hcnt_next  = 2'd0;
            acc_next   = 16'h0000;
          end else begin
            fail = 1'b1;
          end
        end
        jsu_pkg::PH_HEX2: begin
          if (hv[4]) begin
            fail = 1'b1;
          end else begin
            acc_next = acc_sh;
            if (hcnt == 2'd3) begin
              hcnt_next = 2'd0;
              if (acc_sh < 16'hDC00 || acc_sh > 16'hDFFF) begin
                fail = 1'b1;
              end else begin
                push_run.bytes[0] = {5'b11110, cp21[20:18]};
                push_run.bytes[1] = {2'b10, cp21[17:12]};
                push_run.bytes[2] = {2'b10, cp21[11:6]};
                push_run.bytes[3] = {2'b10, cp21[5:0]};
                push_run.cnt      = 3'd4;
                phase_next        = jsu_pkg::PH_BODY;
                fcu_next          = 16'h0000;
              end
            end else begin
              hcnt_next = hcnt + 2'd1;
            end
          end
        end
        default: fail = 1'b1;
      endcase
      if (fail || done) begin
        push_run      = '0;
        push_run.cnt  = 3'd1;
        push_run.kind = fail ? jsu_pkg::KIND_ERR : jsu_pkg::KIND_DONE;
        phase_next    = jsu_pkg::PH_IDLE;
        hcnt_next     = 2'd0;
        fcu_next      = 16'h0000;
        acc_next      = 16'h0000;
      end
    end
  end

  assign push = take && (push_run.cnt != 3'd0);

endmodule

// ----- rtl/core/jsu_queue.sv -----
// Small queue of result runs between the parser and the output sequencer.
module jsu_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jsu_pkg::run_t push_run,
  input  logic          pop,
  output jsu_pkg::run_t head,
  output logic          head_valid,
  output logic          full
);

  jsu_pkg::run_t              entries [jsu_pkg::QDEPTH];
  logic [jsu_pkg::QAW-1:0]    wr_ptr;
  logic [jsu_pkg::QAW-1:0]    rd_ptr;
  logic [jsu_pkg::QCW-1:0]    count;

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == jsu_pkg::QCW'(jsu_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ----- rtl/core/jsu_back.sv -----
// Back end: walks the head run one result per cycle, while out_stall is low, into the output register.
module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  jsu_pkg::run_t head,
  input  logic          head_valid,
  output logic          pop,
  input  logic          out_stall,
  output logic          out_valid,
  output logic [7:0]    out_byte,
  output logic [1:0]    kind,
  output logic          last_of_run
);

  logic [1:0] idx;
  logic       load;
  logic       at_last;

  assign load    = head_valid && (!out_valid || !out_stall);
  assign at_last = ({1'b0, idx} == (head.cnt - 3'd1));
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (!out_valid || !out_stall) out_valid <= head_valid;
      if (load) idx <= at_last ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= head.bytes[idx];
      kind        <= head.kind;
      last_of_run <= at_last;
    end
  end

endmodule

// ----- rtl/core/json_string_unescape_to_utf8.sv -----
// Top level of the JSON string unescaper: parser, run queue and output sequencer.
//
//   Channel  Signals                              Request
//   input    in_valid, in_stall, in_byte          one byte of the quoted string
//   output   out_valid, out_stall, out_byte,      one decoded byte, or a complete
//            kind, last_of_run                    or error marker
//
// The parser takes one input byte per cycle whenever the run queue has room.
// Each byte produces a run of zero to four results, which the output sequencer
// emits one per cycle while out_stall is low; a four-entry run queue absorbs
// the bursts. A queued run passes through the run queue and then the output
// register on its way to out_valid.
// Synchronous reset returns the parser to the idle phase and empties the queue.
// in_stall rises only when the queue is full; out_stall freezes the output
// register while the parser keeps running until the queue fills.
module json_string_unescape_to_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       last_of_run
);

  `include "json_string_unescape_to_utf8_assert.svh"

  logic          take;
  logic          push;
  jsu_pkg::run_t push_run;
  logic          front_idle;
  logic          pop;
  jsu_pkg::run_t head;
  logic          head_valid;
  logic          q_full;

  // A byte is taken whenever the queue has space for the run it may cause.
  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;

  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .in_byte  (in_byte),
    .push     (push),
    .push_run (push_run),
    .idle     (front_idle)
  );

  jsu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_run   (push_run),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .kind        (kind),
    .last_of_run (last_of_run)
  );

  // A complete or error marker always stands alone and carries a zero byte.
  `JSU_ASSERT_NOW(a_marker_alone, out_valid && kind != jsu_pkg::KIND_DATA, last_of_run && out_byte == 8'h00, "marker result is not a lone zero byte")
  // Completing or failing a string puts the parser back to waiting for a quote.
  `JSU_ASSERT_NEXT(a_end_to_idle, push && push_run.kind != jsu_pkg::KIND_DATA, front_idle, "parser not idle after string end")
  // The sequencer never retires a run that is not there.
  `JSU_ASSERT_NOW(a_pop_has_head, pop, head_valid, "run popped from an empty queue")

endmodule
